>>> design/ksme_pkg.sv
// ksme_pkg: shared types and constants for the knob scan event block
// used by ksme_front, ksme_fifo, ksme_back and knob_scan_to_midi_events
package ksme_pkg;

   localparam int CH_W       = 3;
   localparam int SAMPLE_W   = 10;
   localparam int LEVEL_W    = 7;
   localparam int BANK_W     = 3;
   localparam int BEND_W     = 14;
   localparam int MAP_W      = 24;
   localparam int CTL_W      = 6;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int FIFO_DEPTH = 4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_BUTTON_CHANNEL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_CHANNEL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_LOW       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_HIGH      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONTROLLER_MAP = 3'd4;

   // register reset values
   localparam logic [CH_W-1:0]   RST_BUTTON_CHANNEL = 3'd3;
   localparam logic [CH_W-1:0]   RST_PITCH_CHANNEL  = 3'd1;
   localparam logic [BEND_W-1:0] RST_DEAD_LOW       = 14'd8000;
   localparam logic [BEND_W-1:0] RST_DEAD_HIGH      = 14'd8160;
   localparam logic [MAP_W-1:0]  RST_CONTROLLER_MAP = 24'd3488800;

   // message kinds on rsp_tuser
   localparam logic [KIND_W-1:0] MSG_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] MSG_CONTROL = 2'd1;
   localparam logic [KIND_W-1:0] MSG_PITCH   = 2'd2;

   // level cap for control values
   localparam logic [7:0]         LEVEL_LIMIT = 8'd126;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd127;
   localparam logic [7:0]         BUTTON_BIAS = 8'd30;

   typedef enum logic [1:0] {
      HANDLE_BUTTON,
      HANDLE_PITCH,
      HANDLE_CONTROL
   } handle_type;

   typedef struct packed {
      logic [CH_W-1:0]   button_channel;
      logic [CH_W-1:0]   pitch_channel;
      logic [BEND_W-1:0] dead_low;
      logic [BEND_W-1:0] dead_high;
      logic [MAP_W-1:0]  controller_map;
   } cfg_type;

   // one classified sample handed from the front to the back
   typedef struct packed {
      handle_type          handling;
      logic                changed;
      logic [SAMPLE_W-1:0] sample;
      logic [LEVEL_W-1:0]  level;
      logic [BANK_W-1:0]   bank;
      logic [CH_W-1:0]     channel;
      logic [CH_W-1:0]     next_channel;
   } item_type;

endpackage

>>> design/knob_scan_to_midi_events.sv
// knob_scan_to_midi_events: top level, csr registers and front/queue/back wiring
// depends on ksme_pkg, ksme_front, ksme_fifo and ksme_back
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   req     | in        | req_tvalid/tready  | tdata[9:0] sample
//   rsp     | out       | rsp_tvalid/tready  | tuser msg_kind, tdata ctl/values/chans
//   csr     | in        | csr_we             | csr_index register, csr_wdata value
//
// one sample in and one result out per cycle sustained while rsp_tready stays high;
// a sample taken into the empty queue is stored there, then registered by the back
// (front is combinational into the queue, the back registers the result)
// synchronous active-high reset clears the scan counter, bank, channel history,
// queue and result valid, and loads the register defaults; no clearing pass
// req_tready drops only when the four-entry queue is full, so rsp stalls fill
// the queue before the request side sees backpressure
module knob_scan_to_midi_events #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: sample
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // [9:0] sample
   // response
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [5:0] controller_number,
                                                        // [12:6] value_low,
                                                        // [19:13] value_high,
                                                        // [22:20] scanned_channel,
                                                        // [25:23] next_channel
   output logic [ksme_pkg::KIND_W-1:0]     rsp_tuser,   // [1:0] msg_kind
   // register writes
   input  logic                            csr_we,
   input  logic [ksme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ksme_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ksme_pkg::cfg_type  cfg_ff;
   ksme_pkg::item_type front_item;
   ksme_pkg::item_type head_item;
   logic               fifo_not_full;
   logic               fifo_not_empty;
   logic               fifo_pop;
   logic               req_accept;

   logic [ksme_pkg::CTL_W-1:0]   controller_number;
   logic [ksme_pkg::LEVEL_W-1:0] value_low;
   logic [ksme_pkg::LEVEL_W-1:0] value_high;
   logic [ksme_pkg::CH_W-1:0]    scanned_channel;
   logic [ksme_pkg::CH_W-1:0]    next_channel;

   // register file; writes to unlisted indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_channel <= ksme_pkg::RST_BUTTON_CHANNEL;
         cfg_ff.pitch_channel  <= ksme_pkg::RST_PITCH_CHANNEL;
         cfg_ff.dead_low       <= ksme_pkg::RST_DEAD_LOW;
         cfg_ff.dead_high      <= ksme_pkg::RST_DEAD_HIGH;
         cfg_ff.controller_map <= ksme_pkg::RST_CONTROLLER_MAP;
      end else if (csr_we) begin
         case (csr_index)
            ksme_pkg::REG_BUTTON_CHANNEL: cfg_ff.button_channel <= csr_wdata[2:0];
            ksme_pkg::REG_PITCH_CHANNEL:  cfg_ff.pitch_channel  <= csr_wdata[2:0];
            ksme_pkg::REG_DEAD_LOW:       cfg_ff.dead_low       <= csr_wdata[13:0];
            ksme_pkg::REG_DEAD_HIGH:      cfg_ff.dead_high      <= csr_wdata[13:0];
            ksme_pkg::REG_CONTROLLER_MAP: cfg_ff.controller_map <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // a request is taken whenever the queue has room
   assign req_tready = fifo_not_full;
   assign req_accept = req_tvalid && fifo_not_full;

   // front: scan position, history compare, bank tracking
   ksme_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .sample (req_tdata[9:0]),
      .cfg    (cfg_ff),
      .item   (front_item)
   );

   // decoupling queue
   ksme_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (front_item),
      .not_full  (fifo_not_full),
      .pop       (fifo_pop),
      .not_empty (fifo_not_empty),
      .head_item (head_item)
   );

   // back: message formation and output register
   ksme_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (fifo_not_empty),
      .head_item         (head_item),
      .pop               (fifo_pop),
      .cfg               (cfg_ff),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .msg_kind          (rsp_tuser),
      .controller_number (controller_number),
      .value_low         (value_low),
      .value_high        (value_high),
      .scanned_channel   (scanned_channel),
      .next_channel      (next_channel)
   );

   // pack result fields, controller_number in the lowest bits
   assign rsp_tdata = {6'b000000, next_channel, scanned_channel, value_high,
                       value_low, controller_number};

endmodule

>>> design/ksme_front.sv
// ksme_front: scan counter, per-channel history and bank; classifies each sample
// depends on ksme_pkg
module ksme_front #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [ksme_pkg::SAMPLE_W-1:0] sample,
   input  ksme_pkg::cfg_type             cfg,
   output ksme_pkg::item_type            item
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [ksme_pkg::SAMPLE_W-1:0] last_ff [NUM_CHANNELS];
   logic [ksme_pkg::SAMPLE_W-1:0] last_in;
   logic [IDX_W-1:0]              scan_ff;
   logic [IDX_W-1:0]              scan_in;
   logic [ksme_pkg::BANK_W-1:0]   bank_ff;
   logic [ksme_pkg::BANK_W-1:0]   bank_in;

   logic [ksme_pkg::CH_W-1:0]     channel;
   logic [ksme_pkg::SAMPLE_W-1:0] old_value;
   logic [7:0]                    button_sum;
   logic [ksme_pkg::BANK_W-1:0]   button_value;
   logic [10:0]                   level_sum;
   logic [7:0]                    level_raw;
   logic [ksme_pkg::LEVEL_W-1:0]  level;

   assign channel   = ksme_pkg::CH_W'(scan_ff);
   assign old_value = last_ff[scan_ff];
   assign scan_in   = (scan_ff == IDX_W'(NUM_CHANNELS - 1)) ? '0 : scan_ff + 1'b1;

   // bank buttons: ((s >> 3) + 30) >> 5
   assign button_sum   = {1'b0, sample[9:3]} + ksme_pkg::BUTTON_BIAS;
   assign button_value = button_sum[7:5];

   // control level: (s + 3) >> 3 capped at 127
   assign level_sum = {1'b0, sample} + 11'd3;
   assign level_raw = level_sum[10:3];
   assign level     = (level_raw > ksme_pkg::LEVEL_LIMIT) ? ksme_pkg::LEVEL_MAX
                                                          : level_raw[6:0];

   always_comb begin
      item.sample       = sample;
      item.level        = level;
      item.bank         = bank_ff;
      item.channel      = channel;
      item.next_channel = ksme_pkg::CH_W'(scan_in);
      bank_in           = bank_ff;
      if (channel == cfg.button_channel) begin
         item.handling = ksme_pkg::HANDLE_BUTTON;
         item.changed  = 1'b0;
         last_in       = ksme_pkg::SAMPLE_W'(button_value);
         bank_in       = (last_in == old_value) ? button_value : '0;
      end else if (channel == cfg.pitch_channel) begin
         item.handling = ksme_pkg::HANDLE_PITCH;
         item.changed  = (sample != old_value);
         last_in       = sample;
      end else begin
         item.handling = ksme_pkg::HANDLE_CONTROL;
         last_in       = ksme_pkg::SAMPLE_W'(level);
         item.changed  = (last_in != old_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         bank_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_ff[i] <= '0;
         end
      end else if (accept) begin
         scan_ff          <= scan_in;
         bank_ff          <= bank_in;
         last_ff[scan_ff] <= last_in;
      end
   end

endmodule

>>> design/ksme_fifo.sv
// ksme_fifo: short queue of classified samples between front and back
// depends on ksme_pkg
module ksme_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ksme_pkg::item_type push_item,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output ksme_pkg::item_type head_item
);

   localparam int PTR_W = $clog2(ksme_pkg::FIFO_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   ksme_pkg::item_type  store_ff [ksme_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   assign not_full  = (count_ff != CNT_W'(ksme_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = store_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // occupancy stays within the queue
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ksme_pkg::FIFO_DEPTH))
      else $error("queue count beyond depth");

   // no write into a full queue, no read from an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push |-> not_full) and (pop |-> not_empty))
      else $error("queue overflow or underflow");

   // pointer difference matches the count, modulo the depth
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      PTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[PTR_W-1:0])
      else $error("queue pointers disagree with count");

endmodule

>>> design/ksme_back.sv
// ksme_back: turns classified samples into messages, holds the result register
// depends on ksme_pkg
module ksme_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  ksme_pkg::item_type                 head_item,
   output logic                               pop,
   input  ksme_pkg::cfg_type                  cfg,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [ksme_pkg::KIND_W-1:0]        msg_kind,
   output logic [ksme_pkg::CTL_W-1:0]         controller_number,
   output logic [ksme_pkg::LEVEL_W-1:0]       value_low,
   output logic [ksme_pkg::LEVEL_W-1:0]       value_high,
   output logic [ksme_pkg::CH_W-1:0]          scanned_channel,
   output logic [ksme_pkg::CH_W-1:0]          next_channel
);

   logic                          valid_ff;
   logic [ksme_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [ksme_pkg::CTL_W-1:0]    ctl_ff, ctl_in;
   logic [ksme_pkg::LEVEL_W-1:0]  lo_ff, lo_in;
   logic [ksme_pkg::LEVEL_W-1:0]  hi_ff, hi_in;
   logic [ksme_pkg::CH_W-1:0]     ch_ff;
   logic [ksme_pkg::CH_W-1:0]     nxt_ff;

   logic [ksme_pkg::BEND_W-1:0]   bend;
   logic                          bend_sent;
   logic [2:0]                    map_entry;
   logic [6:0]                    bank_ten;
   logic [6:0]                    ctl_sum;

   assign pop = head_valid && (!valid_ff || out_ready);

   assign bend      = {head_item.sample, 4'b0000};
   assign bend_sent = (bend > cfg.dead_high) || (bend < cfg.dead_low);
   assign map_entry = 3'(cfg.controller_map >> (5'(head_item.channel) * 5'd3));
   assign bank_ten  = {1'b0, head_item.bank, 3'b000} + {3'b000, head_item.bank, 1'b0};
   assign ctl_sum   = {4'b0000, map_entry} + bank_ten;

   always_comb begin
      kind_in = ksme_pkg::MSG_NONE;
      ctl_in  = '0;
      lo_in   = '0;
      hi_in   = '0;
      case (head_item.handling)
         ksme_pkg::HANDLE_PITCH: begin
            if (head_item.changed && bend_sent) begin
               kind_in = ksme_pkg::MSG_PITCH;
               lo_in   = bend[6:0];
               hi_in   = bend[13:7];
            end
         end
         ksme_pkg::HANDLE_CONTROL: begin
            if (head_item.changed) begin
               kind_in = ksme_pkg::MSG_CONTROL;
               ctl_in  = ctl_sum[5:0];
               lo_in   = head_item.level;
            end
         end
         default: begin
            kind_in = ksme_pkg::MSG_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= kind_in;
         ctl_ff  <= ctl_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         ch_ff   <= head_item.channel;
         nxt_ff  <= head_item.next_channel;
      end
   end

   assign out_valid         = valid_ff;
   assign msg_kind          = kind_ff;
   assign controller_number = ctl_ff;
   assign value_low         = lo_ff;
   assign value_high        = hi_ff;
   assign scanned_channel   = ch_ff;
   assign next_channel      = nxt_ff;

endmodule

>>> tb/knob_scan_to_midi_events_tb.sv
// knob_scan_to_midi_events_tb: self-checking bench for the knob scan event block
// depends on ksme_pkg and knob_scan_to_midi_events; predicts every result in step with
// the request stream and checks each response field by field
module knob_scan_to_midi_events_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_CH       = 8;
   localparam int HALF_CLK   = 4;
   localparam int RESET_LEN  = 10;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 8;
   localparam int PHASE_LEN  = 120;

   // one predicted or observed event
   typedef struct packed {
      logic [ksme_pkg::KIND_W-1:0]  kind;
      logic [ksme_pkg::CTL_W-1:0]   ctl;
      logic [ksme_pkg::LEVEL_W-1:0] lo;
      logic [ksme_pkg::LEVEL_W-1:0] hi;
      logic [ksme_pkg::CH_W-1:0]    scanned;
      logic [ksme_pkg::CH_W-1:0]    next_ch;
   } midi_event_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [15:0]                     req_tdata  = '0;   // [9:0] sample
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [31:0]                     rsp_tdata;         // [5:0] ctl, [12:6] lo, [19:13] hi,
                                                       // [22:20] scanned, [25:23] next
   logic [ksme_pkg::KIND_W-1:0]     rsp_tuser;         // [1:0] msg_kind
   logic                            csr_we     = 1'b0;
   logic [ksme_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [ksme_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   knob_scan_to_midi_events #(.NUM_CHANNELS(N_CH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_CLK) clock = ~clock;

   // ---------------------------------------------------------------
   // scanner model: register copy plus per-channel history, scan
   // position and bank, all advanced once per accepted request
   // ---------------------------------------------------------------
   ksme_pkg::cfg_type dev_cfg = '{ksme_pkg::RST_BUTTON_CHANNEL, ksme_pkg::RST_PITCH_CHANNEL,
                                  ksme_pkg::RST_DEAD_LOW, ksme_pkg::RST_DEAD_HIGH,
                                  ksme_pkg::RST_CONTROLLER_MAP};
   logic [ksme_pkg::SAMPLE_W-1:0] chan_hist [N_CH];
   logic [ksme_pkg::CH_W-1:0]     scan_ch  = '0;
   logic [ksme_pkg::BANK_W-1:0]   cur_bank = '0;

   midi_event_type                predicted_events [$];
   logic [ksme_pkg::SAMPLE_W-1:0] pending_samples  [$];
   int                            mismatch_count = 0;

   initial begin
      foreach (chan_hist[i]) chan_hist[i] = '0;
   end

   function automatic midi_event_type scan_event(input logic [ksme_pkg::SAMPLE_W-1:0] s);
      logic [ksme_pkg::CH_W-1:0]     ch;
      logic [ksme_pkg::SAMPLE_W-1:0] prev;
      logic [ksme_pkg::BEND_W-1:0]   bend;
      ksme_pkg::handle_type          how;
      int                            lvl;
      int                            ctl_sum;
      midi_event_type                ev;
      ch   = scan_ch;
      prev = chan_hist[ch];
      ev   = '0;
      ev.kind    = ksme_pkg::MSG_NONE;
      ev.scanned = ch;
      // button selection wins when both selectors point at the same channel
      if (ch == dev_cfg.button_channel)
         how = ksme_pkg::HANDLE_BUTTON;
      else if (ch == dev_cfg.pitch_channel)
         how = ksme_pkg::HANDLE_PITCH;
      else
         how = ksme_pkg::HANDLE_CONTROL;
      case (how)
         ksme_pkg::HANDLE_BUTTON: begin
            // bank only latches when the button level repeats
            lvl = ((int'(s) >> 3) + 30) >> 5;
            cur_bank = (lvl == int'(prev)) ? lvl[ksme_pkg::BANK_W-1:0] : '0;
            chan_hist[ch] = lvl[ksme_pkg::SAMPLE_W-1:0];
         end
         ksme_pkg::HANDLE_PITCH: begin
            if (s != prev) begin
               bend = {s, 4'b0000};
               // outside the dead zone only
               if (bend > dev_cfg.dead_high || bend < dev_cfg.dead_low) begin
                  ev.kind = ksme_pkg::MSG_PITCH;
                  ev.lo   = bend[6:0];
                  ev.hi   = bend[13:7];
               end
            end
            chan_hist[ch] = s;
         end
         default: begin
            lvl = (int'(s) + 3) >> 3;
            if (lvl > 126) lvl = 127;
            if (lvl != int'(prev)) begin
               ctl_sum = int'(dev_cfg.controller_map[3*ch +: 3]) + 10 * int'(cur_bank);
               ev.kind = ksme_pkg::MSG_CONTROL;
               ev.ctl  = ctl_sum[ksme_pkg::CTL_W-1:0];
               ev.lo   = lvl[ksme_pkg::LEVEL_W-1:0];
            end
            chan_hist[ch] = lvl[ksme_pkg::SAMPLE_W-1:0];
         end
      endcase
      ev.next_ch = (int'(ch) + 1 >= N_CH) ? '0 : ch + 1'b1;
      scan_ch = ev.next_ch;
      return ev;
   endfunction

   // ---------------------------------------------------------------
   // idle shaping: mostly short gaps, now and then a long one, and
   // calm stretches with no gaps at all
   // ---------------------------------------------------------------
   logic calm = 1'b0;
   int   tick = 0;

   always @(posedge clock) begin
      tick <= tick + 1;
      if (tick % 200 == 0) calm <= ($urandom_range(0, 3) == 0);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------
   // request driver: inputs move on the falling edge
   // ---------------------------------------------------------------
   logic req_taken = 1'b0;   // set at the rising edge that accepted a request
   int   req_gap   = 0;

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predicted_events.push_back(scan_event(req_tdata[ksme_pkg::SAMPLE_W-1:0]));
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            req_tdata  <= {6'b0, pending_samples.pop_front()};
            req_tvalid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready with random stalls
   int rsp_stall = 0;

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // ---------------------------------------------------------------
   // response monitor: compare against the oldest prediction
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : response_monitor
      midi_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_events.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual tdata %h tuser %0d",
                     $realtime, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = predicted_events.pop_front();
            check_field("msg_kind",          int'(want.kind),    int'(rsp_tuser));
            check_field("controller_number", int'(want.ctl),     int'(rsp_tdata[5:0]));
            check_field("value_low",         int'(want.lo),      int'(rsp_tdata[12:6]));
            check_field("value_high",        int'(want.hi),      int'(rsp_tdata[19:13]));
            check_field("scanned_channel",   int'(want.scanned), int'(rsp_tdata[22:20]));
            check_field("next_channel",      int'(want.next_ch), int'(rsp_tdata[25:23]));
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   // opening sweep, channel order 0..7: extremes, level cap edge, repeats,
   // bank latch and release, bend on both dead-zone boundaries and outside
   logic [ksme_pkg::SAMPLE_W-1:0] opening_sweep [0:25] = '{
      10'd1023, 10'd1023, 10'd0,    10'd1023, 10'd1012, 10'd1,    10'd7,    10'd1023,
      10'd0,    10'd500,  10'd5,    10'd1023, 10'd1013, 10'd1,    10'd1023, 10'd1023,
      10'd1023, 10'd510,  10'd1023, 10'd0,    10'd1013, 10'd1023, 10'd0,    10'd0,
      10'd8,    10'd499
   };

   logic [ksme_pkg::SAMPLE_W-1:0] stim_prev [N_CH];
   logic [ksme_pkg::CH_W-1:0]     stim_ch   = '0;
   int                            hold_bank = 0;

   task automatic queue_sample(input logic [ksme_pkg::SAMPLE_W-1:0] s);
      pending_samples.push_back(s);
      stim_prev[stim_ch] = s;
      stim_ch = (int'(stim_ch) + 1 >= N_CH) ? '0 : stim_ch + 1'b1;
   endtask

   function automatic logic [ksme_pkg::SAMPLE_W-1:0] clamp_sample(input int v);
      if (v < 0) return '0;
      if (v > 1023) return 10'd1023;
      return v[ksme_pkg::SAMPLE_W-1:0];
   endfunction

   // mostly plausible knob traffic for the channel the scan will be on
   function automatic logic [ksme_pkg::SAMPLE_W-1:0] pick_sample(
      input logic [ksme_pkg::CH_W-1:0] ch);
      int r;
      int lo8;
      int hi8;
      int edge_base;
      r = $urandom_range(0, 99);
      if (r < 20) return ksme_pkg::SAMPLE_W'($urandom_range(0, 1023));
      if (ch == dev_cfg.button_channel) begin
         // hold a button level for a while so banks latch
         if ($urandom_range(0, 9) < 3) hold_bank = $urandom_range(0, 4);
         lo8 = (hold_bank == 0) ? 0 : 32 * hold_bank - 30;
         hi8 = (hold_bank == 4) ? 127 : 32 * hold_bank + 1;
         return clamp_sample(8 * $urandom_range(hi8, lo8) + $urandom_range(0, 7));
      end
      if (ch == dev_cfg.pitch_channel) begin
         if (r < 45) return stim_prev[ch];
         if (r < 70) begin
            edge_base = $urandom_range(0, 1) ? int'(dev_cfg.dead_low >> 4)
                                             : int'(dev_cfg.dead_high >> 4);
            return clamp_sample(edge_base + $urandom_range(0, 2) - 1);
         end
         return ksme_pkg::SAMPLE_W'($urandom_range(0, 1023));
      end
      if (r < 45) return clamp_sample(int'(stim_prev[ch]) + $urandom_range(0, 6) - 3);
      if (r < 55) begin
         case ($urandom_range(0, 3))
            0:       return 10'd0;
            1:       return 10'd1012;
            2:       return 10'd1013;
            default: return 10'd1023;
         endcase
      end
      return ksme_pkg::SAMPLE_W'($urandom_range(0, 1023));
   endfunction

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_tvalid || predicted_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ksme_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [ksme_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         ksme_pkg::REG_BUTTON_CHANNEL:
            dev_cfg.button_channel = val[ksme_pkg::CH_W-1:0];
         ksme_pkg::REG_PITCH_CHANNEL:
            dev_cfg.pitch_channel  = val[ksme_pkg::CH_W-1:0];
         ksme_pkg::REG_DEAD_LOW:
            dev_cfg.dead_low       = val[ksme_pkg::BEND_W-1:0];
         ksme_pkg::REG_DEAD_HIGH:
            dev_cfg.dead_high      = val[ksme_pkg::BEND_W-1:0];
         ksme_pkg::REG_CONTROLLER_MAP:
            dev_cfg.controller_map = val[ksme_pkg::MAP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input int bc, input int pc, input int dl, input int dh,
                            input int cmap);
      write_reg(ksme_pkg::REG_BUTTON_CHANNEL, ksme_pkg::CSR_DATA_W'(bc));
      write_reg(ksme_pkg::REG_PITCH_CHANNEL,  ksme_pkg::CSR_DATA_W'(pc));
      write_reg(ksme_pkg::REG_DEAD_LOW,       ksme_pkg::CSR_DATA_W'(dl));
      write_reg(ksme_pkg::REG_DEAD_HIGH,      ksme_pkg::CSR_DATA_W'(dh));
      write_reg(ksme_pkg::REG_CONTROLLER_MAP, ksme_pkg::CSR_DATA_W'(cmap));
      @(negedge clock);
      csr_we <= 1'b0;
      repeat (PHASE_LEN) queue_sample(pick_sample(stim_ch));
      wait_idle();
   endtask

   initial begin : stimulus
      int dl;
      foreach (stim_prev[i]) stim_prev[i] = '0;
      repeat (RESET_LEN) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening with the reset register values
      foreach (opening_sweep[i]) queue_sample(opening_sweep[i]);
      wait_idle();

      dl = $urandom_range(6000, 9000);
      run_phase($urandom_range(0, 7), $urandom_range(0, 7), dl,
                dl + $urandom_range(0, 400), $urandom_range(0, 24'hFFFFFF));
      // both selectors on one channel: buttons win
      run_phase(5, 5, 8000, 8160, $urandom_range(0, 24'hFFFFFF));
      // dead zone covers everything, map all zero
      run_phase(0, 7, 0, 16383, 0);
      // dead zone empty, map all ones
      run_phase(7, 0, 16383, 0, 24'hFFFFFF);
      run_phase(2, 6, int'(ksme_pkg::RST_DEAD_LOW), int'(ksme_pkg::RST_DEAD_HIGH),
                int'(ksme_pkg::RST_CONTROLLER_MAP));
      dl = $urandom_range(0, 16383);
      run_phase($urandom_range(0, 7), $urandom_range(0, 7), dl,
                $urandom_range(0, 16383), $urandom_range(0, 24'hFFFFFF));

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && predicted_events.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog on total run length
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_CAP) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
design/ksme_pkg.sv
design/ksme_front.sv
design/ksme_fifo.sv
design/ksme_back.sv
design/knob_scan_to_midi_events.sv
tb/knob_scan_to_midi_events_tb.sv
